### src/rrm_pkg.sv
// ----------------------------------------------------------------------------
// Ranked matcher package
// Shared types, constants and helper functions of the ranked matcher.
// ----------------------------------------------------------------------------
package rrm_pkg;

    localparam int unsigned MaxResourcesDefault = 16;
    localparam int unsigned DurationBitsDefault = 10;
    localparam int unsigned MaskBits = 16;
    localparam int unsigned CfgIdxBits = 2;
    localparam int unsigned WordBits = 32;
    localparam int unsigned RankBits = 31;
    localparam logic [31:0] LfsrTaps = 32'h8020_0003;

    typedef enum logic [1:0] {
        OP_REQ,
        OP_DUR,
        OP_START,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        CFG_COUNT,
        CFG_RESAMPLE,
        CFG_SEED,
        CFG_SPARE
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic start_step;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic idx_ok;
        logic last;
        logic out_busy;
    } t_stat;

    function automatic logic [31:0] lfsr_next(input logic [31:0] w);
        lfsr_next = (w >> 1) ^ (w[0] ? LfsrTaps : 32'd0);
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

### src/rrm_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one input item of the ranked matcher.
// ----------------------------------------------------------------------------
interface rrm_in_if #(
    parameter int unsigned DURATION_BITS = rrm_pkg::DurationBitsDefault
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic [15:0]              eligible_mask;
    logic [3:0]               resource_index;
    logic [DURATION_BITS-1:0] duration_value;

    modport source (output valid, opcode, eligible_mask, resource_index, duration_value,
                    input ready);
    modport sink (input valid, opcode, eligible_mask, resource_index, duration_value,
                  output ready);
endinterface

### src/rrm_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item of the ranked matcher.
// ----------------------------------------------------------------------------
interface rrm_out_if;
    logic        valid;
    logic        ready;
    logic        matched;
    logic [3:0]  granted_resource;
    logic [31:0] match_total;

    modport source (output valid, matched, granted_resource, match_total, input ready);
    modport sink (input valid, matched, granted_resource, match_total, output ready);
endinterface

### src/rrm_ctrl.sv
// ----------------------------------------------------------------------------
// Ranked matcher controller
// Sequences the scan, start, modulo and result phases of each item.
// ----------------------------------------------------------------------------
module rrm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rrm_pkg::t_stat i_stat,
    output rrm_pkg::t_cmd  o_cmd
);
    rrm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rrm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = rrm_pkg::S_DONE;
                end
            end
            rrm_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.last) begin
                    n_state = rrm_pkg::S_DONE;
                end
            end
            rrm_pkg::S_START: begin
                o_cmd.start_step = 1'b1;
                if (i_stat.last) begin
                    n_state = rrm_pkg::S_DONE;
                end
            end
            rrm_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.last) begin
                    n_state = rrm_pkg::S_DONE;
                end
            end
            rrm_pkg::S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = rrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrm_pkg::S_IDLE;
            end
        endcase
        if (r_state == rrm_pkg::S_IDLE && i_in_valid) begin
            unique case (i_stat.op)
                rrm_pkg::OP_REQ:   n_state = rrm_pkg::S_SCAN;
                rrm_pkg::OP_START: n_state = rrm_pkg::S_START;
                rrm_pkg::OP_DUR:   n_state = i_stat.idx_ok ? rrm_pkg::S_DIV : rrm_pkg::S_DONE;
                rrm_pkg::OP_NOP:   n_state = rrm_pkg::S_DONE;
            endcase
        end
    end
endmodule

### src/rrm_dp.sv
// ----------------------------------------------------------------------------
// Ranked matcher datapath
// Resource tables, rank generator, modulo unit, selection and result register.
// ----------------------------------------------------------------------------
module rrm_dp #(
    parameter int unsigned MAX_RESOURCES = rrm_pkg::MaxResourcesDefault,
    parameter int unsigned DURATION_BITS = rrm_pkg::DurationBitsDefault
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rrm_pkg::CfgIdxBits-1:0]     i_cfg_idx,
    input  logic [rrm_pkg::WordBits-1:0]       i_cfg_wdata,
    input  logic [1:0]                         i_opcode,
    input  logic [15:0]                        i_mask,
    input  logic [3:0]                         i_ridx,
    input  logic [DURATION_BITS-1:0]           i_dval,
    input  rrm_pkg::t_cmd                      i_cmd,
    output rrm_pkg::t_stat                     o_stat,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_matched,
    output logic [3:0]                         o_granted,
    output logic [31:0]                        o_total
);
    localparam int unsigned IW = $clog2(MAX_RESOURCES);
    localparam int unsigned CW = (IW > 5) ? IW : 5;
    localparam int unsigned MW = (MAX_RESOURCES > 16) ? MAX_RESOURCES : 16;
    localparam int unsigned DB = DURATION_BITS;

    logic [4:0]               r_count;
    logic                     r_resample;
    logic [31:0]              r_seed;

    logic [31:0]              r_free [MAX_RESOURCES];
    logic [30:0]              r_rank [MAX_RESOURCES];
    logic [DB-1:0]            r_dur  [MAX_RESOURCES];
    logic [DB-1:0]            r_phase[MAX_RESOURCES];
    logic [31:0]              r_lfsr;
    logic [31:0]              r_arr;
    logic [31:0]              r_grants;

    rrm_pkg::t_op             r_op;
    logic [MW-1:0]            r_mask;
    logic [IW-1:0]            r_ridx;
    logic                     r_idx_ok;
    logic [DB-1:0]            r_dval;
    logic [CW-1:0]            r_cnt;
    logic [DB:0]              r_rem;
    logic                     r_found;
    logic [IW-1:0]            r_best;
    logic [30:0]              r_best_rank;
    logic [DB-1:0]            r_best_dur;

    logic                     r_valid;
    logic                     r_matched;
    logic [3:0]               r_granted;
    logic [31:0]              r_total;

    logic [IW-1:0]            j;
    logic [31:0]              n_act;
    logic                     active;
    logic [31:0]              lfsr_nx;
    logic                     draw;
    logic [30:0]              cur_rank;
    logic                     cand;
    logic [DB:0]              rem_sh;
    logic [DB:0]              rem_nx;
    logic [DB-1:0]            phase_inc;
    logic [DB-1:0]            dval_eff;
    logic [31:0]              n_grants;

    assign j = r_cnt[IW-1:0];
    assign n_act = (32'(r_count) > MAX_RESOURCES) ? 32'(MAX_RESOURCES) : 32'(r_count);
    assign active = 32'(r_cnt) < n_act;
    assign lfsr_nx = rrm_pkg::lfsr_next(r_lfsr);
    assign draw = active && r_resample && (r_phase[j] == '0);
    assign cur_rank = draw ? lfsr_nx[30:0] : r_rank[j];
    assign cand = active && r_mask[j] && (r_free[j] <= r_arr);
    assign phase_inc = r_phase[j] + 1'b1;
    assign rem_sh = {r_rem[DB-1:0], r_arr[5'd31 - r_cnt[4:0]]};
    assign rem_nx = (rem_sh >= {1'b0, r_dval}) ? rem_sh - {1'b0, r_dval} : rem_sh;
    assign dval_eff = (i_dval == '0) ? DB'(1) : i_dval;
    assign n_grants = rrm_pkg::sat_add(r_grants, 32'd1);

    always_comb begin
        o_stat.op = rrm_pkg::t_op'(i_opcode);
        o_stat.idx_ok = 32'(i_ridx) < MAX_RESOURCES;
        o_stat.out_busy = r_valid && !i_ready;
        if (r_op == rrm_pkg::OP_DUR) begin
            o_stat.last = r_cnt[4:0] == 5'd31;
        end else begin
            o_stat.last = 32'(r_cnt) == MAX_RESOURCES - 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd16;
            r_resample <= 1'b1;
            r_seed <= 32'd1;
        end else if (i_cfg_we) begin
            unique case (rrm_pkg::t_cfg'(i_cfg_idx))
                rrm_pkg::CFG_COUNT:    r_count <= i_cfg_wdata[4:0];
                rrm_pkg::CFG_RESAMPLE: r_resample <= i_cfg_wdata[0];
                rrm_pkg::CFG_SEED:     r_seed <= i_cfg_wdata;
                rrm_pkg::CFG_SPARE:    r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_RESOURCES; k++) begin
                r_free[k] <= '0;
                r_rank[k] <= '0;
                r_dur[k] <= DB'(1);
                r_phase[k] <= '0;
            end
            r_lfsr <= 32'd1;
            r_arr <= '0;
            r_grants <= '0;
            r_op <= rrm_pkg::OP_NOP;
            r_idx_ok <= 1'b0;
            r_cnt <= '0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_op <= rrm_pkg::t_op'(i_opcode);
                r_mask <= MW'(i_mask);
                r_ridx <= IW'(i_ridx);
                r_idx_ok <= o_stat.idx_ok;
                r_dval <= dval_eff;
                r_cnt <= '0;
                r_rem <= '0;
                r_found <= 1'b0;
                r_best <= '0;
                if (rrm_pkg::t_op'(i_opcode) == rrm_pkg::OP_START) begin
                    r_lfsr <= (r_seed == '0) ? 32'd1 : r_seed;
                    r_arr <= '0;
                    r_grants <= '0;
                end
            end
            if (i_cmd.scan_step) begin
                r_cnt <= r_cnt + 1'b1;
                if (draw) begin
                    r_lfsr <= lfsr_nx;
                    r_rank[j] <= lfsr_nx[30:0];
                end
                if (cand && (!r_found || cur_rank < r_best_rank)) begin
                    r_found <= 1'b1;
                    r_best <= j;
                    r_best_rank <= cur_rank;
                    r_best_dur <= r_dur[j];
                end
                if (r_arr != 32'hFFFF_FFFF) begin
                    r_phase[j] <= (phase_inc == r_dur[j]) ? '0 : phase_inc;
                end
            end
            if (i_cmd.start_step) begin
                r_cnt <= r_cnt + 1'b1;
                r_free[j] <= '0;
                r_phase[j] <= '0;
                if (active) begin
                    r_lfsr <= lfsr_nx;
                    r_rank[j] <= lfsr_nx[30:0];
                end
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
                r_rem <= rem_nx;
            end
            if (i_cmd.finish) begin
                r_valid <= 1'b1;
                r_matched <= 1'b0;
                r_granted <= '0;
                r_total <= r_grants;
                unique case (r_op)
                    rrm_pkg::OP_REQ: begin
                        r_arr <= rrm_pkg::sat_add(r_arr, 32'd1);
                        if (r_found) begin
                            r_free[r_best] <= rrm_pkg::sat_add(r_arr, 32'(r_best_dur));
                            r_grants <= n_grants;
                            r_matched <= 1'b1;
                            r_granted <= 4'(r_best);
                            r_total <= n_grants;
                        end
                    end
                    rrm_pkg::OP_DUR: begin
                        if (r_idx_ok) begin
                            r_dur[r_ridx] <= r_dval;
                            r_phase[r_ridx] <= r_rem[DB-1:0];
                        end
                    end
                    rrm_pkg::OP_START: r_lfsr <= r_lfsr;
                    rrm_pkg::OP_NOP:   r_lfsr <= r_lfsr;
                endcase
            end
        end
    end

    assign o_valid = r_valid;
    assign o_matched = r_matched;
    assign o_granted = r_granted;
    assign o_total = r_total;
endmodule

### src/ranked_reusable_resource_matcher.sv
// ----------------------------------------------------------------------------
// Ranked reusable resource matcher
// Grants each request the free eligible resource with the smallest random rank.
// ----------------------------------------------------------------------------
// A request makes one pass over the resource table.
// A start makes one pass over the resource table, drawing one rank per cycle for each active entry.
// A duration load runs a bit-serial modulo of the arrival index.
// Other opcodes and loads to an index out of range go straight to the result phase.
// One item is in work at a time.
// Reset is synchronous and active low; it restores all tables, the configuration and the state and valid registers.
module ranked_reusable_resource_matcher #(
    parameter int unsigned MAX_RESOURCES = rrm_pkg::MaxResourcesDefault,
    parameter int unsigned DURATION_BITS = rrm_pkg::DurationBitsDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rrm_in_if.sink                         i_req,
    rrm_out_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [rrm_pkg::CfgIdxBits-1:0] i_cfg_idx,
    input  logic [rrm_pkg::WordBits-1:0]   i_cfg_wdata
);
    rrm_pkg::t_cmd  cmd;
    rrm_pkg::t_stat stat;

    rrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rrm_dp #(
        .MAX_RESOURCES (MAX_RESOURCES),
        .DURATION_BITS (DURATION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_opcode    (i_req.opcode),
        .i_mask      (i_req.eligible_mask),
        .i_ridx      (i_req.resource_index),
        .i_dval      (i_req.duration_value),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_rsp.valid),
        .i_ready     (o_rsp.ready),
        .o_matched   (o_rsp.matched),
        .o_granted   (o_rsp.granted_resource),
        .o_total     (o_rsp.match_total)
    );
endmodule
